@@ rtl/assert_macros.svh @@
// Assertion shorthands shared by the RTL.
// Each expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/cca_pkg.sv @@
package cca_pkg;

	// Grid geometry and cell width.
	localparam int GRID_SIDE  = 512;
	localparam int MAX_RANGE  = 8;
	localparam int STATE_BITS = 5;

	// Fixed widths of the item fields and registers.
	localparam int MODE_BITS  = 2;
	localparam int POS_BITS   = 9;
	localparam int CELL_BITS  = 5;
	localparam int NS_BITS    = 6;
	localparam int RNG_REG_BITS = 4;
	localparam int THR_BITS   = 9;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 9;

	// Derived widths and counts.
	localparam int COORD_BITS = $clog2(GRID_SIDE);
	localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_BITS  = $clog2(CELL_COUNT);
	localparam int RNG_BITS   = $clog2(MAX_RANGE + 1);
	localparam int OFS_BITS   = RNG_BITS + 1;
	localparam int CRD_BITS   = ((COORD_BITS > POS_BITS) ? COORD_BITS : POS_BITS) + 2;
	localparam int NBR_MAX    = (2 * MAX_RANGE + 1) * (2 * MAX_RANGE + 1);
	localparam int CNT_BITS   = $clog2(NBR_MAX + 1);

	// Register reset values.
	localparam logic [NS_BITS-1:0]      NUM_STATES_RST = NS_BITS'(18);
	localparam logic [RNG_REG_BITS-1:0] RANGE_RST      = RNG_REG_BITS'(6);
	localparam logic [THR_BITS-1:0]     THRESHOLD_RST  = THR_BITS'(7);
	localparam logic                    MOORE_RST      = 1'b0;

	typedef logic [STATE_BITS-1:0] state_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_LOAD   = 2'd0,
		MODE_UPDATE = 2'd1,
		MODE_SWAP   = 2'd2,
		MODE_READ   = 2'd3
	} mode_e;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_NUM_STATES = 2'd0,
		CFG_RANGE      = 2'd1,
		CFG_THRESHOLD  = 2'd2,
		CFG_MOORE      = 2'd3
	} cfg_idx_e;

	typedef struct packed {
		logic [MODE_BITS-1:0] mode;
		logic [POS_BITS-1:0]  pos_x;
		logic [POS_BITS-1:0]  pos_y;
		logic [CELL_BITS-1:0] cell_value;
	} in_item_t;

	typedef struct packed {
		logic [CELL_BITS-1:0] cell_out;
		logic                 advanced;
	} out_item_t;

	// Access request from the sequencer to the grid memories.
	typedef struct packed {
		logic   rd_en;
		logic   rd_bank_b;
		addr_t  rd_addr;
		logic   wr_en;
		logic   wr_bank_b;
		addr_t  wr_addr;
		state_t wr_data;
	} grid_req_t;

	// Highest usable state once the state count is held within its legal span.
	function automatic state_t last_state(input logic [NS_BITS-1:0] ns);
		int n;
		n = int'(ns);
		if (n < 2) begin
			n = 2;
		end
		if (n > (1 << STATE_BITS)) begin
			n = 1 << STATE_BITS;
		end
		return STATE_BITS'(n - 1);
	endfunction

endpackage

@@ rtl/cca_grid.sv @@
module cca_grid import cca_pkg::*; (
	input  logic      clk,
	input  grid_req_t req,
	output state_t    rd_data
);

	state_t bank_a_mem [CELL_COUNT];
	state_t bank_b_mem [CELL_COUNT];

	state_t rd_a_q;
	state_t rd_b_q;
	logic   rd_sel_b_q;

	always_ff @(posedge clk) begin
		if (req.wr_en && !req.wr_bank_b) begin
			bank_a_mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_a_q <= bank_a_mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en && req.wr_bank_b) begin
			bank_b_mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_b_q     <= bank_b_mem[req.rd_addr];
			rd_sel_b_q <= req.rd_bank_b;
		end
	end

	assign rd_data = rd_sel_b_q ? rd_b_q : rd_a_q;

endmodule

@@ rtl/cyclic_cellular_automaton_step.sv @@
// Two-generation cyclic cellular automaton engine on a GRID_SIDE by GRID_SIDE grid of
// STATE_BITS-bit cells, one item at a time. A load writes a clamped state into the
// current generation, a read returns a cell of the current generation, a swap exchanges
// the generations, and an update works out one cell's successor, counts the neighbours
// of the current generation that already hold it and writes either the successor or the
// old state into the next generation. The neighbourhood is scanned through a single read
// port of the grid memory, one cell per cycle, with one shared compare and counter, over
// a (2r+1) by (2r+1) square where r is the effective range (6 at reset, 8 at most).
// Cells outside the scan shape or off the grid are not read but are still stepped through.
// An item addressing a cell off the grid leaves the grid untouched. The input stall is
// raised from acceptance until the result has moved into the output register, which then
// holds it while the next item is taken. Grid memory is not cleared: every cell must be
// loaded before it is read or scanned. Configuration may be written only while no item
// is in progress.
`include "assert_macros.svh"

module cyclic_cellular_automaton_step import cca_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_item_t                 in_item,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_item_t                out_item,
	input  logic                     cfg_wen,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SUCC,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_RDATA,
		S_DONE
	} fsm_t;

	fsm_t state_q;

	// Configuration registers.
	logic [NS_BITS-1:0]      num_states_q;
	logic [RNG_REG_BITS-1:0] range_q;
	logic [THR_BITS-1:0]     threshold_q;
	logic                    moore_q;

	// The item being worked on.
	mode_e                mode_q;
	logic [POS_BITS-1:0]  x_q;
	logic [POS_BITS-1:0]  y_q;
	logic [CELL_BITS-1:0] val_q;

	logic bank_a_cur_q;

	// Update working registers.
	state_t                      cur_q;
	state_t                      succ_q;
	logic signed [OFS_BITS-1:0]  dx_q;
	logic signed [OFS_BITS-1:0]  dy_q;
	logic                        chk_s1;
	logic [CNT_BITS-1:0]         count_q;
	state_t                      res_q;
	logic                        adv_q;

	logic      out_valid_q;
	out_item_t out_item_q;

	grid_req_t grid_req;
	state_t    rd_data;

	// Effective range and state limit.
	logic [RNG_BITS-1:0]        rng;
	logic signed [OFS_BITS-1:0] rng_s;
	state_t                     last;

	// Neighbour currently addressed by the scan.
	logic signed [CRD_BITS-1:0] nx;
	logic signed [CRD_BITS-1:0] ny;
	logic [RNG_BITS-1:0]        adx;
	logic [RNG_BITS-1:0]        ady;
	logic                       nb_on_grid;
	logic                       nb_in_shape;
	logic                       nb_check;
	logic                       scan_last;
	addr_t                      nb_addr;
	addr_t                      cell_addr;
	logic                       on_grid;
	logic                       adv_c;
	state_t                     load_c;

	always_comb begin
		if (range_q == '0) begin
			rng = RNG_BITS'(1);
		end else if (int'(range_q) > MAX_RANGE) begin
			rng = RNG_BITS'(MAX_RANGE);
		end else begin
			rng = RNG_BITS'(range_q);
		end
	end

	assign rng_s = signed'(OFS_BITS'(rng));
	assign last  = last_state(num_states_q);

	assign on_grid   = (int'(x_q) < GRID_SIDE) && (int'(y_q) < GRID_SIDE);
	assign cell_addr = ADDR_BITS'(x_q) * ADDR_BITS'(GRID_SIDE) + ADDR_BITS'(y_q);

	assign nx  = signed'(CRD_BITS'(x_q)) + CRD_BITS'(dx_q);
	assign ny  = signed'(CRD_BITS'(y_q)) + CRD_BITS'(dy_q);
	assign adx = RNG_BITS'((dx_q < 0) ? -dx_q : dx_q);
	assign ady = RNG_BITS'((dy_q < 0) ? -dy_q : dy_q);

	assign nb_on_grid = (nx >= 0) && (nx < signed'(CRD_BITS'(GRID_SIDE)))
		&& (ny >= 0) && (ny < signed'(CRD_BITS'(GRID_SIDE)));
	assign nb_in_shape = moore_q
		|| ((RNG_BITS + 1)'(adx) + (RNG_BITS + 1)'(ady) <= (RNG_BITS + 1)'(rng));
	assign nb_check  = nb_on_grid && nb_in_shape;
	assign scan_last = (dx_q == rng_s) && (dy_q == rng_s);
	assign nb_addr   = ADDR_BITS'(unsigned'(nx)) * ADDR_BITS'(GRID_SIDE)
		+ ADDR_BITS'(unsigned'(ny));

	// The centre cell is scanned too, but never matches, as its state differs from its successor.
	assign adv_c  = int'(count_q) >= int'(threshold_q);
	assign load_c = (int'(val_q) > int'(last)) ? last : STATE_BITS'(val_q);

	// Grid accesses for each step of the sequence.
	always_comb begin
		grid_req = '0;
		unique case (state_q)
			S_START: begin
				unique case (mode_q)
					MODE_LOAD: begin
						grid_req.wr_en     = on_grid;
						grid_req.wr_bank_b = !bank_a_cur_q;
						grid_req.wr_addr   = cell_addr;
						grid_req.wr_data   = load_c;
					end
					MODE_UPDATE, MODE_READ: begin
						grid_req.rd_en     = on_grid;
						grid_req.rd_bank_b = !bank_a_cur_q;
						grid_req.rd_addr   = cell_addr;
					end
					MODE_SWAP: begin
						grid_req.rd_en = 1'b0;
					end
				endcase
			end
			S_SCAN: begin
				grid_req.rd_en     = nb_check;
				grid_req.rd_bank_b = !bank_a_cur_q;
				grid_req.rd_addr   = nb_addr;
			end
			S_DECIDE: begin
				// The next generation lives in the bank that is not current.
				grid_req.wr_en     = 1'b1;
				grid_req.wr_bank_b = bank_a_cur_q;
				grid_req.wr_addr   = cell_addr;
				grid_req.wr_data   = adv_c ? succ_q : cur_q;
			end
			S_IDLE, S_SUCC, S_DRAIN, S_RDATA, S_DONE: begin
				grid_req.rd_en = 1'b0;
			end
		endcase
	end

	cca_grid u_grid (
		.clk     (clk),
		.req     (grid_req),
		.rd_data (rd_data)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= NUM_STATES_RST;
			range_q      <= RANGE_RST;
			threshold_q  <= THRESHOLD_RST;
			moore_q      <= MOORE_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx_e'(cfg_index))
				CFG_NUM_STATES: num_states_q <= cfg_data[NS_BITS-1:0];
				CFG_RANGE:      range_q      <= cfg_data[RNG_REG_BITS-1:0];
				CFG_THRESHOLD:  threshold_q  <= cfg_data[THR_BITS-1:0];
				CFG_MOORE:      moore_q      <= cfg_data[0];
			endcase
		end
	end

	// Item payload, captured at acceptance.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_q <= mode_e'(in_item.mode);
			x_q    <= in_item.pos_x;
			y_q    <= in_item.pos_y;
			val_q  <= in_item.cell_value;
		end
	end

	// Sequencer: state, scan counters, match counter and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			bank_a_cur_q <= 1'b1;
			chk_s1       <= 1'b0;
			count_q      <= '0;
			cur_q        <= '0;
			succ_q       <= '0;
			dx_q         <= '0;
			dy_q         <= '0;
			res_q        <= '0;
			adv_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_item_q   <= '0;
		end else begin
			// One neighbour read is compared per cycle, in the cycle after it was issued.
			chk_s1 <= (state_q == S_SCAN) && nb_check;
			if (chk_s1 && (rd_data == succ_q)) begin
				count_q <= count_q + CNT_BITS'(1);
			end

			// In the final step a new result replaces the one being taken.
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					res_q <= '0;
					adv_q <= 1'b0;
					unique case (mode_q)
						MODE_LOAD: begin
							state_q <= S_DONE;
						end
						MODE_UPDATE: begin
							state_q <= on_grid ? S_SUCC : S_DONE;
						end
						MODE_SWAP: begin
							bank_a_cur_q <= !bank_a_cur_q;
							state_q      <= S_DONE;
						end
						MODE_READ: begin
							state_q <= on_grid ? S_RDATA : S_DONE;
						end
					endcase
				end
				S_SUCC: begin
					// A stored state at or above the last one wraps to zero.
					cur_q   <= rd_data;
					succ_q  <= (rd_data >= last) ? '0 : rd_data + STATE_BITS'(1);
					count_q <= '0;
					dx_q    <= -rng_s;
					dy_q    <= -rng_s;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_last) begin
						state_q <= S_DRAIN;
					end else if (dy_q == rng_s) begin
						dy_q <= -rng_s;
						dx_q <= dx_q + OFS_BITS'(1);
					end else begin
						dy_q <= dy_q + OFS_BITS'(1);
					end
				end
				S_DRAIN: begin
					// The last neighbour read is being compared in this cycle.
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					res_q   <= adv_c ? succ_q : cur_q;
					adv_q   <= adv_c;
					state_q <= S_DONE;
				end
				S_RDATA: begin
					res_q   <= rd_data;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q         <= 1'b1;
						out_item_q.cell_out <= CELL_BITS'(res_q);
						out_item_q.advanced <= adv_q;
						state_q             <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// A swap flips the current bank exactly once.
	`ASSERT_NEXT(a_swap_toggles, state_q == S_START && mode_q == MODE_SWAP,
		bank_a_cur_q != $past(bank_a_cur_q))

	// The next generation is never written while the neighbourhood is being read.
	`ASSERT_IMPL(a_no_write_in_scan, state_q == S_SCAN || state_q == S_DRAIN, !grid_req.wr_en)

	// Loads and swaps return an all-zero result.
	`ASSERT_IMPL(a_zero_result,
		state_q == S_DONE && (mode_q == MODE_LOAD || mode_q == MODE_SWAP),
		res_q == '0 && !adv_q)

	// The match count can never exceed the size of the largest neighbourhood.
	`ASSERT_IMPL(a_count_bound, state_q == S_DECIDE, int'(count_q) <= NBR_MAX)

endmodule
